// ===== hw/rtl/ccie_pkg.sv =====
// ccie_pkg: beat types, divider and table-port structs for the coprime counter
// no dependencies; imported by every module of the block
package ccie_pkg;

	localparam int N_W   = 63;  // width of range top and count
	localparam int K_W   = 16;  // width of target and of every divisor
	localparam int DCNT_W = 6;  // divider step counter width

	// query beat, range top in the upper bits
	typedef struct packed {
		logic [N_W-1:0] upper_limit;
		logic [K_W-1:0] target;
	} query_t;

	// result beat
	typedef struct packed {
		logic [N_W-1:0] coprime_total;
		logic           target_too_large;
	} result_t;

	// divider request, start is a single-cycle pulse
	typedef struct packed {
		logic           start;
		logic [N_W-1:0] dividend;
		logic [K_W-1:0] divisor;
	} div_req_t;

	// divider response, done pulses for one cycle with the results
	typedef struct packed {
		logic           done;
		logic [N_W-1:0] quotient;
		logic [K_W-1:0] remainder;
	} div_rsp_t;

	// factor table read request
	typedef struct packed {
		logic           en;
		logic [K_W-1:0] addr;
	} tbl_rd_t;

endpackage

// ===== hw/rtl/ccie_div.sv =====
// ccie_div: restoring divider, 63-bit dividend by 16-bit divisor, one bit a cycle
// depends on ccie_pkg
module ccie_div
	import ccie_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic              busy_q;
	logic              done_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [N_W-1:0]    quo_q;
	logic [K_W-1:0]    rem_q;
	logic [K_W-1:0]    dvs_q;
	logic [K_W:0]      trial;
	logic              fits;

	// shift in the next dividend bit and try a subtract
	assign trial = {rem_q, quo_q[N_W-1]};
	assign fits  = (trial >= {1'b0, dvs_q});

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				if (req.start) begin
					busy_q <= 1'b1;
					cnt_q  <= '0;
				end
			end else begin
				cnt_q <= cnt_q + DCNT_W'(1);
				if (cnt_q == DCNT_W'(N_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (!busy_q) begin
			if (req.start) begin
				quo_q <= req.dividend;
				rem_q <= '0;
				dvs_q <= req.divisor;
			end
		end else begin
			quo_q <= {quo_q[N_W-2:0], fits};
			rem_q <= fits ? K_W'(trial - {1'b0, dvs_q}) : trial[K_W-1:0];
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

// ===== hw/rtl/ccie_sieve.sv =====
// ccie_sieve: smallest-prime-factor table, cleared then filled by a sieve after reset
// depends on ccie_pkg; owns the table memory and serves query reads once filled
module ccie_sieve
	import ccie_pkg::*;
#(
	parameter int MAX_K = 65535
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tbl_rd_t                        rd,
	output logic                           ready,
	output logic [$clog2(MAX_K + 1)-1:0]   rd_data
);

	localparam int KW = $clog2(MAX_K + 1);

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_SCAN  = 6'b000010,
		S_CHK   = 6'b000100,
		S_MARK  = 6'b001000,
		S_DRAIN = 6'b010000,
		S_DONE  = 6'b100000
	} sv_state_t;

	sv_state_t      state_q;
	logic [KW-1:0]  addr_q;   // clear address, then scan candidate
	logic [KW:0]    j_q;      // multiple being marked
	logic [KW:0]    nj;
	logic           pend_q;
	logic [KW-1:0]  pend_addr_q;
	logic [KW-1:0]  mem [MAX_K + 1];
	logic           we;
	logic [KW-1:0]  waddr;
	logic [KW-1:0]  wdata;
	logic           re;
	logic [KW-1:0]  raddr;
	logic           last_cand;

	assign nj        = j_q + {1'b0, addr_q};
	assign last_cand = (addr_q == KW'(MAX_K));

	// memory port selection
	always_comb begin
		we    = 1'b0;
		waddr = addr_q;
		wdata = '0;
		re    = 1'b0;
		raddr = addr_q;
		case (state_q)
			S_CLEAR: begin
				we = 1'b1;
			end
			S_SCAN: begin
				re = 1'b1;
			end
			S_MARK, S_DRAIN: begin
				we    = pend_q && (rd_data == '0);
				waddr = pend_addr_q;
				wdata = addr_q;
				re    = (state_q == S_MARK);
				raddr = j_q[KW-1:0];
			end
			S_DONE: begin
				re    = rd.en;
				raddr = KW'(rd.addr);
			end
			default: begin
				re = 1'b0;
			end
		endcase
	end

	// table memory
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_data <= mem[raddr];
		end
	end

	// clear and sieve sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			addr_q      <= '0;
			j_q         <= '0;
			pend_q      <= 1'b0;
			pend_addr_q <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					if (last_cand) begin
						addr_q  <= KW'(2);
						state_q <= S_SCAN;
					end else begin
						addr_q <= addr_q + KW'(1);
					end
				end
				S_SCAN: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (rd_data == '0) begin
						j_q     <= {1'b0, addr_q};
						state_q <= S_MARK;
					end else if (last_cand) begin
						state_q <= S_DONE;
					end else begin
						addr_q  <= addr_q + KW'(1);
						state_q <= S_SCAN;
					end
				end
				S_MARK: begin
					pend_q      <= 1'b1;
					pend_addr_q <= j_q[KW-1:0];
					j_q         <= nj;
					if (nj > (KW + 1)'(MAX_K)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					pend_q <= 1'b0;
					if (last_cand) begin
						state_q <= S_DONE;
					end else begin
						addr_q  <= addr_q + KW'(1);
						state_q <= S_SCAN;
					end
				end
				S_DONE: begin
					state_q <= S_DONE;
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

	assign ready = (state_q == S_DONE);

endmodule

// ===== hw/rtl/coprime_count_inclusion_exclusion.sv =====
// coprime_count_inclusion_exclusion: top level and query sequencer
// depends on ccie_pkg, ccie_sieve and ccie_div
//
// Counts the integers in 1..n that share no factor with k.
// Query channel (query_valid/query_ready, query_t) carries n and k; result
// channel (result_valid/result_ready, result_t) returns one beat per query.
// After reset the factor table is cleared and then filled by a sieve of
// Eratosthenes; query_ready stays low until it is complete.
// A query with k of 0 or 1, or above MAX_K, skips factoring and goes straight to the output stage.
// Otherwise the distinct primes of k are read from the table, each stripped
// from k with the shared divider, then for every subset of the m primes the
// product is built one prime at a time and n is divided by it once.
// The iterative divider sets most of the time that a query takes.
// One query is worked at a time. A result waits in the output register while
// result_ready is low; the next query may be accepted meanwhile and its result
// is held back until the register is free.
module coprime_count_inclusion_exclusion
	import ccie_pkg::*;
#(
	parameter int MAX_K      = 65535,
	parameter int MAX_PRIMES = 6
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    query_valid,
	output logic    query_ready,
	input  query_t  query,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	localparam int KW  = $clog2(MAX_K + 1);
	localparam int MW  = $clog2(MAX_PRIMES + 1);
	localparam int PIW = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;
	localparam int SW  = MAX_PRIMES + 1;

	typedef enum logic [6:0] {
		T_IDLE   = 7'b0000001,
		T_FAC_RD = 7'b0000010,
		T_FAC_CK = 7'b0000100,
		T_DIVP   = 7'b0001000,
		T_PROD   = 7'b0010000,
		T_DIVN   = 7'b0100000,
		T_OUT    = 7'b1000000
	} top_state_t;

	top_state_t     state_q;
	logic [N_W-1:0] n_q;
	logic [K_W-1:0] rest_q;
	logic [K_W-1:0] p_q;
	logic [MW-1:0]  m_q;
	logic [K_W-1:0] primes_q [MAX_PRIMES];
	logic [SW-1:0]  s_q;
	logic [MW-1:0]  j_q;
	logic [K_W-1:0] d_q;
	logic           odd_q;
	logic [N_W-1:0] total_q;
	result_t        res_q;
	logic           out_valid_q;
	result_t        out_q;

	logic           tbl_ready;
	logic [KW-1:0]  tbl_data;
	tbl_rd_t        tbl_rd;
	div_req_t       div_req;
	div_rsp_t       div_rsp;
	logic [K_W-1:0] p_new;
	logic           too_large;
	logic           more_primes;
	logic           last_subset;
	logic [31:0]    prod;
	logic           out_free;

	ccie_sieve #(.MAX_K(MAX_K)) u_sieve (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd      (tbl_rd),
		.ready   (tbl_ready),
		.rd_data (tbl_data)
	);

	ccie_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign p_new       = K_W'(tbl_data);
	assign too_large   = (32'(query.target) > 32'(MAX_K));
	assign more_primes = (rest_q > K_W'(1)) && (m_q < MW'(MAX_PRIMES));
	assign last_subset = ((s_q + SW'(1)) == (SW'(1) << m_q));
	assign prod        = 32'(d_q) * 32'(primes_q[j_q[PIW-1:0]]);
	assign out_free    = !out_valid_q || result_ready;
	assign query_ready = (state_q == T_IDLE) && tbl_ready;

	// table read for factoring
	always_comb begin
		tbl_rd.en   = (state_q == T_FAC_RD) && more_primes;
		tbl_rd.addr = rest_q;
	end

	// divider launches
	always_comb begin
		div_req = '0;
		case (state_q)
			T_FAC_CK: begin
				div_req.start    = (tbl_data >= KW'(2));
				div_req.dividend = N_W'(rest_q);
				div_req.divisor  = p_new;
			end
			T_DIVP: begin
				div_req.start    = div_rsp.done && (div_rsp.remainder == '0);
				div_req.dividend = N_W'(div_rsp.quotient[K_W-1:0]);
				div_req.divisor  = p_q;
			end
			T_PROD: begin
				div_req.start    = (j_q == m_q);
				div_req.dividend = n_q;
				div_req.divisor  = d_q;
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	// query sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			m_q     <= '0;
			s_q     <= '0;
			j_q     <= '0;
		end else begin
			case (state_q)
				T_IDLE: begin
					if (query_valid && query_ready) begin
						m_q <= '0;
						if (query.target == K_W'(1) || query.target == '0 || too_large) begin
							state_q <= T_OUT;
						end else begin
							state_q <= T_FAC_RD;
						end
					end
				end
				T_FAC_RD: begin
					if (more_primes) begin
						state_q <= T_FAC_CK;
					end else begin
						s_q     <= '0;
						j_q     <= '0;
						state_q <= T_PROD;
					end
				end
				T_FAC_CK: begin
					if (tbl_data >= KW'(2)) begin
						m_q     <= m_q + MW'(1);
						state_q <= T_DIVP;
					end else begin
						s_q     <= '0;
						j_q     <= '0;
						state_q <= T_PROD;
					end
				end
				T_DIVP: begin
					if (div_rsp.done && div_rsp.remainder != '0) begin
						state_q <= T_FAC_RD;
					end
				end
				T_PROD: begin
					if (j_q == m_q) begin
						state_q <= T_DIVN;
					end else begin
						j_q <= j_q + MW'(1);
					end
				end
				T_DIVN: begin
					if (div_rsp.done) begin
						j_q <= '0;
						if (last_subset) begin
							state_q <= T_OUT;
						end else begin
							s_q     <= s_q + SW'(1);
							state_q <= T_PROD;
						end
					end
				end
				T_OUT: begin
					if (out_free) begin
						state_q <= T_IDLE;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			T_IDLE: begin
				n_q                    <= query.upper_limit;
				rest_q                 <= query.target;
				res_q.target_too_large <= (query.target > K_W'(1)) && too_large;
				res_q.coprime_total    <= (query.target == K_W'(1)) ? query.upper_limit : '0;
				total_q                <= '0;
			end
			T_FAC_CK: begin
				p_q <= p_new;
				if (tbl_data >= KW'(2)) begin
					primes_q[m_q[PIW-1:0]] <= p_new;
				end
				d_q   <= K_W'(1);
				odd_q <= 1'b0;
			end
			T_FAC_RD: begin
				d_q   <= K_W'(1);
				odd_q <= 1'b0;
			end
			T_DIVP: begin
				if (div_rsp.done && div_rsp.remainder == '0) begin
					rest_q <= div_rsp.quotient[K_W-1:0];
				end
			end
			T_PROD: begin
				if (j_q != m_q && s_q[j_q]) begin
					d_q   <= prod[K_W-1:0];
					odd_q <= !odd_q;
				end
			end
			T_DIVN: begin
				if (div_rsp.done) begin
					d_q   <= K_W'(1);
					odd_q <= 1'b0;
					if (odd_q) begin
						total_q <= total_q - div_rsp.quotient;
					end else begin
						total_q <= total_q + div_rsp.quotient;
					end
					if (last_subset) begin
						res_q.coprime_total <= odd_q ? (total_q - div_rsp.quotient)
						                             : (total_q + div_rsp.quotient);
					end
				end
			end
			default: begin
				p_q <= p_q;
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == T_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == T_OUT && out_free) begin
			out_q <= res_q;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	// queries only once the table is filled
	a_ready_needs_table: assert property (@(posedge clk) disable iff (!arst_n)
		query_ready |-> tbl_ready)
		else $error("query accepted before factor table complete");

	// an accepted query always leaves idle
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(query_valid && query_ready) |=> (state_q != T_IDLE))
		else $error("sequencer stayed idle after accepting a query");

	// flagged results carry a zero count
	a_flag_zero_total: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.target_too_large) |-> (result.coprime_total == '0))
		else $error("oversized target with nonzero count");

	// divisor of any divider launch is never zero
	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> (div_req.divisor != '0))
		else $error("divider launched with zero divisor");

	// a result is only loaded when the output slot is free
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |=> (result_valid && $stable(result)))
		else $error("pending result overwritten");

endmodule
